// ===== design/uts_pkg.sv =====
`default_nettype none

package uts_pkg;

   // Input beat: one raw payload byte and its end-of-payload mark
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // Output beat: one sanitized byte, or the terminating NUL
   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_text;
   } rsp_type;

   localparam int MaxResults = 5;

   localparam logic [15:0] CapacityReset = 16'd256;

   localparam logic [7:0] ChrNul      = 8'h00;
   localparam logic [7:0] ChrTab      = 8'h09;
   localparam logic [7:0] ChrLf       = 8'h0A;
   localparam logic [7:0] ChrCr       = 8'h0D;
   localparam logic [7:0] ChrSpace    = 8'h20;
   localparam logic [7:0] ChrQuestion = 8'h3F;
   localparam logic [7:0] ChrDel      = 8'h7F;
   localparam logic [7:0] ChrAsciiEnd = 8'h80;

   localparam logic [7:0] Lead2Lo   = 8'hC2;
   localparam logic [7:0] Lead2Hi   = 8'hDF;
   localparam logic [7:0] Lead3E0   = 8'hE0;
   localparam logic [7:0] Lead3ED   = 8'hED;
   localparam logic [7:0] Lead3Hi   = 8'hEF;
   localparam logic [7:0] Lead4F0   = 8'hF0;
   localparam logic [7:0] Lead4F4   = 8'hF4;
   localparam logic [7:0] ContLo    = 8'h80;
   localparam logic [7:0] ContHi    = 8'hBF;
   localparam logic [7:0] ContE0Lo  = 8'hA0;
   localparam logic [7:0] ContEDHi  = 8'h9F;
   localparam logic [7:0] ContF0Lo  = 8'h90;
   localparam logic [7:0] ContF4Hi  = 8'h8F;

endpackage

`default_nettype wire

// ===== design/utf8_text_sanitiser.sv =====
`default_nettype none
// Latency: an accepted byte's first result beat is offered on the cycle after acceptance.
// Throughput: one byte per cycle while each byte yields at most one beat and rsp_stall
//   is low; a byte with more beats (up to five) keeps the single result buffer until its last beat leaves.
// Reset (synchronous, active high): capacity returns to 256, the decoder state and the
//   written count clear, and the result buffer empties.
module utf8_text_sanitiser
   import uts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_payload,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);

   // Working copy of the decoder state plus the beats gathered for one input byte
   typedef struct packed {
      logic                  st;
      logic [1:0]            hc;
      logic [2:0]            el;
      logic [15:0]           wc;
      logic [2:0][7:0]       hb;
      logic [2:0]            n;
      logic [4:0][7:0]       bytes;
      logic [4:0]            ends;
   } work_type;

   typedef struct packed {
      logic [2:0] len;
      logic [7:0] lo;
      logic [7:0] hi;
   } lead_type;

   // ------------------------------------------------------------------
   // Decoder step helpers
   // ------------------------------------------------------------------
   function automatic work_type f_emit(work_type w, logic [7:0] v, logic e);
      if (w.n < 3'(MaxResults)) begin
         w.bytes[w.n] = v;
         w.ends[w.n]  = e;
         w.n          = w.n + 3'd1;
      end
      return w;
   endfunction

   function automatic work_type f_halt(work_type w);
      w.st = 1'b1;
      w.hc = 2'd0;
      w.el = 3'd0;
      return w;
   endfunction

   function automatic logic f_fits(work_type w, logic [15:0] limit, logic [2:0] k);
      return ({1'b0, w.wc} + 17'(k)) <= {1'b0, limit};
   endfunction

   function automatic work_type f_emit_one(work_type w, logic [7:0] v, logic [15:0] limit);
      if (!w.st) begin
         if (f_fits(w, limit, 3'd1)) begin
            w    = f_emit(w, v, 1'b0);
            w.wc = w.wc + 16'd1;
         end else begin
            w = f_halt(w);
         end
      end
      return w;
   endfunction

   function automatic work_type f_reject(work_type w, logic [15:0] limit);
      logic [1:0] held;
      held = w.hc;
      w.hc = 2'd0;
      w.el = 3'd0;
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < held) begin
            w = f_emit_one(w, ChrQuestion, limit);
         end
      end
      return w;
   endfunction

   function automatic lead_type f_lead(logic [7:0] b);
      lead_type l;
      l.lo  = ContLo;
      l.hi  = ContHi;
      l.len = 3'd0;
      if (b >= Lead2Lo && b <= Lead2Hi) begin
         l.len = 3'd2;
      end else if (b == Lead3E0) begin
         l.len = 3'd3;
         l.lo  = ContE0Lo;
      end else if (b == Lead3ED) begin
         l.len = 3'd3;
         l.hi  = ContEDHi;
      end else if (b > Lead3E0 && b <= Lead3Hi) begin
         l.len = 3'd3;
      end else if (b == Lead4F0) begin
         l.len = 3'd4;
         l.lo  = ContF0Lo;
      end else if (b > Lead4F0 && b < Lead4F4) begin
         l.len = 3'd4;
      end else if (b == Lead4F4) begin
         l.len = 3'd4;
         l.hi  = ContF4Hi;
      end
      return l;
   endfunction

   function automatic work_type f_start(work_type w, logic [7:0] b, logic [15:0] limit);
      lead_type l;
      l = f_lead(b);
      if (b == ChrNul) begin
         w = f_halt(w);
      end else if (b < ChrAsciiEnd) begin
         if (b == ChrTab || b == ChrLf || b == ChrCr) begin
            w = f_emit_one(w, ChrSpace, limit);
         end else if (b < ChrSpace || b == ChrDel) begin
            w = f_emit_one(w, ChrQuestion, limit);
         end else begin
            w = f_emit_one(w, b, limit);
         end
      end else if (l.len == 3'd0) begin
         w = f_emit_one(w, ChrQuestion, limit);
      end else begin
         w.hb[0] = b;
         w.hc    = 2'd1;
         w.el    = l.len;
      end
      return w;
   endfunction

   function automatic work_type f_take(work_type w, logic [7:0] b, logic [15:0] limit);
      lead_type   l;
      logic [1:0] pos;
      logic [7:0] lo;
      logic [7:0] hi;
      l   = f_lead(w.hb[0]);
      pos = w.hc;
      lo  = (pos == 2'd1) ? l.lo : ContLo;
      hi  = (pos == 2'd1) ? l.hi : ContHi;
      if (w.st) begin
         // drop: payload already stopped
      end else if (pos == 2'd0 || pos == 2'd3) begin
         w.hc = 2'd0;
         w    = f_start(w, b, limit);
      end else if (b >= lo && b <= hi) begin
         if ((3'(pos) + 3'd1) >= w.el) begin
            if (!f_fits(w, limit, 3'(pos) + 3'd1)) begin
               w = f_halt(w);
            end else begin
               w = f_emit(w, w.hb[0], 1'b0);
               if (pos == 2'd2) begin
                  w = f_emit(w, w.hb[1], 1'b0);
               end
               w    = f_emit(w, b, 1'b0);
               w.wc = w.wc + 16'(pos) + 16'd1;
               w.hc = 2'd0;
               w.el = 3'd0;
            end
         end else begin
            w.hb[pos] = b;
            w.hc      = pos + 2'd1;
         end
      end else begin
         w = f_reject(w, limit);
         if (!w.st) begin
            w = f_start(w, b, limit);
         end
      end
      return w;
   endfunction

   // ------------------------------------------------------------------
   // Configuration: capacity register, always ready
   // ------------------------------------------------------------------
   logic [15:0] capacity_ff;
   logic [15:0] limit;

   assign csr_ready = 1'b1;
   // Capacity zero behaves as capacity one: room for the terminator only
   assign limit = (capacity_ff == 16'd0) ? 16'd0 : capacity_ff - 16'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CapacityReset;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_data;
      end
   end

   // ------------------------------------------------------------------
   // Decoder state
   // ------------------------------------------------------------------
   logic            stopped_ff;
   logic [1:0]      held_count_ff;
   logic [2:0]      expected_len_ff;
   logic [15:0]     written_ff;
   logic [2:0][7:0] held_bytes_ff;

   // Result buffer: the beats of one input byte, drained one per cycle while rsp_stall is low
   logic [4:0][7:0] buf_bytes_ff;
   logic [4:0]      buf_ends_ff;
   logic [2:0]      buf_count_ff;
   logic [2:0]      buf_idx_ff;

   logic     req_accept;
   logic     rsp_accept;
   logic     buf_last_beat;
   work_type work_in;

   assign rsp_valid   = (buf_idx_ff != buf_count_ff);
   assign rsp_accept  = rsp_valid && !rsp_stall;
   assign buf_last_beat = (buf_idx_ff + 3'd1) == buf_count_ff;

   // Take a new byte once the buffer is empty or its final beat leaves this cycle
   assign req_stall  = rsp_valid && !(buf_last_beat && !rsp_stall);
   assign req_accept = req_valid && !req_stall;

   assign rsp_payload.out_byte    = buf_bytes_ff[buf_idx_ff];
   assign rsp_payload.end_of_text = buf_ends_ff[buf_idx_ff];

   always_comb begin
      work_in       = '0;
      work_in.st    = stopped_ff;
      work_in.hc    = held_count_ff;
      work_in.el    = expected_len_ff;
      work_in.wc    = written_ff;
      work_in.hb    = held_bytes_ff;
      work_in       = f_take(work_in, req_payload.data_byte, limit);
      if (req_payload.last_byte) begin
         // Flush a cut-off sequence, then terminate and rearm for the next payload
         if (!work_in.st && work_in.hc != 2'd0) begin
            work_in = f_reject(work_in, limit);
         end
         work_in    = f_emit(work_in, ChrNul, 1'b1);
         work_in.hc = 2'd0;
         work_in.el = 3'd0;
         work_in.wc = 16'd0;
         work_in.st = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stopped_ff      <= 1'b0;
         held_count_ff   <= 2'd0;
         expected_len_ff <= 3'd0;
         written_ff      <= 16'd0;
         held_bytes_ff   <= '0;
      end else if (req_accept) begin
         stopped_ff      <= work_in.st;
         held_count_ff   <= work_in.hc;
         expected_len_ff <= work_in.el;
         written_ff      <= work_in.wc;
         held_bytes_ff   <= work_in.hb;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         buf_bytes_ff  <= work_in.bytes;
         buf_ends_ff   <= work_in.ends;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_count_ff <= 3'd0;
         buf_idx_ff   <= 3'd0;
      end else if (req_accept) begin
         buf_count_ff <= work_in.n;
         buf_idx_ff   <= 3'd0;
      end else if (rsp_accept) begin
         buf_idx_ff   <= buf_idx_ff + 3'd1;
      end
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_buf_bounds: assert property (@(posedge clock) disable iff (reset)
      buf_idx_ff <= buf_count_ff && buf_count_ff <= 3'(MaxResults))
      else $error("result buffer index or count out of range");

   a_held_consistent: assert property (@(posedge clock) disable iff (reset)
      held_count_ff != 2'd0 |-> expected_len_ff != 3'd0)
      else $error("held count and expected length disagree");

   a_stopped_empty: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> held_count_ff == 2'd0)
      else $error("sequence pending in a stopped payload");

   a_terminator_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.end_of_text |-> buf_last_beat)
      else $error("terminator is not the final beat of its byte");

   a_last_terminates: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_payload.last_byte |=> rsp_valid && buf_ends_ff[buf_count_ff - 3'd1])
      else $error("last byte did not produce a terminator");

endmodule

`default_nettype wire
